/* src/bpa_pkg.sv */
// Shared constants, codes and types of the bitmap page allocator.
package bpa_pkg;

   // Field widths of the channels.
   localparam int PAGE_W   = 11;
   localparam int STATUS_W = 2;
   localparam int RATE_W   = 7;

   // One usage bitmap word covers this many data pages.
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;
   localparam int NBITS_W   = BIT_W + 1;

   // The zero finder splits a bitmap word into lanes of this size.
   localparam int LANE_BITS = 8;
   localparam int LANES     = WORD_BITS / LANE_BITS;
   localparam int LANE_W    = 3;

   // Default geometry of the page space.
   localparam int PAGES_PER_GROUP_DEF = 64;
   localparam int MAX_GROUPS_DEF      = 16;
   localparam int INITIAL_PAGES_DEF   = 66;

   localparam logic [RATE_W-1:0] GROWTH_RATE_RESET = 7'd16;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_PAGE     = 2'd1,
      STATUS_OUT_OF_SPACE = 2'd2
   } status_type;

   // Finished result handed from the engine to the output register.
   typedef struct packed {
      logic              valid;
      logic [PAGE_W-1:0] page;
      status_type        status;
      logic [PAGE_W-1:0] total;
   } result_type;

endpackage

/* src/bpa_req_if.sv */
// Request channel: command and page number with a valid/ready handshake.
interface bpa_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [bpa_pkg::PAGE_W-1:0] page_number;

   modport source (output valid, output command, output page_number, input ready);
   modport sink   (input valid, input command, input page_number, output ready);
endinterface

/* src/bpa_rsp_if.sv */
// Response channel: result page, status and page count with a valid/ready handshake.
interface bpa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bpa_pkg::PAGE_W-1:0]   result_page;
   logic [bpa_pkg::STATUS_W-1:0] status;
   logic [bpa_pkg::PAGE_W-1:0]   total_pages;

   modport source (output valid, output result_page, output status, output total_pages,
                   input ready);
   modport sink   (input valid, input result_page, input status, input total_pages,
                   output ready);
endinterface

/* src/bpa_csr_if.sv */
// Configuration write channel carrying the growth rate register.
interface bpa_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bpa_pkg::RATE_W-1:0] growth_rate;

   modport source (output valid, output growth_rate, input ready);
   modport sink   (input valid, input growth_rate, output ready);
endinterface

/* src/bpa_sub_step.sv */
// Compare-and-subtract step shared by the group and growth divisions.
module bpa_sub_step #(
   parameter int WIDTH = 12
) (
   input  logic [WIDTH-1:0] minuend,
   input  logic [WIDTH-1:0] subtrahend,
   output logic             ge,
   output logic [WIDTH-1:0] diff
);

   assign ge   = (minuend >= subtrahend);
   assign diff = minuend - subtrahend;

endmodule

/* src/bpa_zero_find.sv */
// Finds the lowest set bit of a 64-bit candidate word in two 8-way levels.
module bpa_zero_find (
   input  logic [bpa_pkg::WORD_BITS-1:0] cand,
   output logic                          found,
   output logic [bpa_pkg::BIT_W-1:0]     index
);

   logic [bpa_pkg::LANES-1:0]  lane_hit;
   logic [bpa_pkg::LANE_W-1:0] lane_pos [bpa_pkg::LANES];
   logic [bpa_pkg::LANE_W-1:0] sel_lane;

   always_comb begin
      for (int i = 0; i < bpa_pkg::LANES; i++) begin
         lane_hit[i] = |cand[i*bpa_pkg::LANE_BITS +: bpa_pkg::LANE_BITS];
         lane_pos[i] = '0;
         for (int j = bpa_pkg::LANE_BITS - 1; j >= 0; j--) begin
            if (cand[i*bpa_pkg::LANE_BITS + j]) begin
               lane_pos[i] = bpa_pkg::LANE_W'(j);
            end
         end
      end
      sel_lane = '0;
      for (int i = bpa_pkg::LANES - 1; i >= 0; i--) begin
         if (lane_hit[i]) begin
            sel_lane = bpa_pkg::LANE_W'(i);
         end
      end
   end

   assign found = |lane_hit;
   assign index = {sel_lane, lane_pos[sel_lane]};

endmodule

/* src/bpa_engine.sv */
// Sequencer, usage bitmap memory and page count of the allocator.
module bpa_engine #(
   parameter int PAGES_PER_GROUP = bpa_pkg::PAGES_PER_GROUP_DEF,
   parameter int MAX_GROUPS      = bpa_pkg::MAX_GROUPS_DEF,
   parameter int INITIAL_PAGES   = bpa_pkg::INITIAL_PAGES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       command,
   input  logic [bpa_pkg::PAGE_W-1:0] page_number,
   input  logic [bpa_pkg::RATE_W-1:0] growth_rate,
   input  logic                       take,
   output logic                       idle,
   output bpa_pkg::result_type        result
);

   localparam int SPAN      = PAGES_PER_GROUP + 1;
   localparam int WPG       = (PAGES_PER_GROUP + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
   localparam int NWORDS    = MAX_GROUPS * WPG;
   localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int SCW       = $clog2(NWORDS + 1);
   localparam int MAX_TOTAL = 1 + MAX_GROUPS * SPAN;
   localparam int CW        = $clog2(MAX_TOTAL + INITIAL_PAGES + (1 << bpa_pkg::PAGE_W));
   localparam int GLW       = $clog2(PAGES_PER_GROUP + 1);
   localparam int QW        = $clog2((1 << bpa_pkg::RATE_W) / PAGES_PER_GROUP + 2);

   localparam logic [CW-1:0]  SPAN_C      = CW'(SPAN);
   localparam logic [CW-1:0]  PPG_C       = CW'(PAGES_PER_GROUP);
   localparam logic [CW-1:0]  WPG_C       = CW'(WPG);
   localparam logic [CW-1:0]  NWORDS_C    = CW'(NWORDS);
   localparam logic [CW-1:0]  MAX_TOTAL_C = CW'(MAX_TOTAL);
   localparam logic [CW-1:0]  WORD_C      = CW'(bpa_pkg::WORD_BITS);
   localparam logic [CW-1:0]  FIRST_DATA  = CW'(2);
   localparam logic [CW-1:0]  INIT_C      = CW'(INITIAL_PAGES);
   localparam logic [SCW-1:0] SCAN_END    = SCW'(NWORDS);
   localparam logic [AW-1:0]  CLEAR_LAST  = AW'(NWORDS - 1);
   localparam logic [GLW-1:0] PPG_G       = GLW'(PAGES_PER_GROUP);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FREE_DIV,
      S_SCAN,
      S_GROW_DIV,
      S_GROW_Q,
      S_GROW_FIN,
      S_RMW_RD,
      S_RMW_WR,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [bpa_pkg::PAGE_W-1:0]   pn_ff, pn_in;
   logic [CW-1:0]                page_total_ff, page_total_in;
   logic [CW-1:0]                rem_ff, rem_in;
   logic [CW-1:0]                wbase_ff, wbase_in;
   logic [QW-1:0]                q_ff, q_in;
   logic [GLW-1:0]               diff_ff, diff_in;
   logic [SCW-1:0]               scan_w_ff, scan_w_in;
   logic [CW-1:0]                issue_base_ff, issue_base_in;
   logic [GLW-1:0]               grp_left_ff, grp_left_in;
   logic                         chk_v_ff, chk_v_in;
   logic [CW-1:0]                chk_base_ff, chk_base_in;
   logic [AW-1:0]                chk_addr_ff, chk_addr_in;
   logic [bpa_pkg::NBITS_W-1:0]  chk_nbits_ff, chk_nbits_in;
   logic [AW-1:0]                upd_addr_ff, upd_addr_in;
   logic [bpa_pkg::BIT_W-1:0]    upd_bit_ff, upd_bit_in;
   logic                         upd_set_ff, upd_set_in;
   logic [bpa_pkg::PAGE_W-1:0]   res_page_ff, res_page_in;
   bpa_pkg::status_type          res_status_ff, res_status_in;

   // Usage bitmap storage.
   logic [bpa_pkg::WORD_BITS-1:0] mem [NWORDS];
   logic [bpa_pkg::WORD_BITS-1:0] rdata_ff;
   logic                          mem_we;
   logic [AW-1:0]                 mem_wa;
   logic [bpa_pkg::WORD_BITS-1:0] mem_wd;
   logic [AW-1:0]                 rd_addr;

   // Shared compare-and-subtract unit.
   logic [CW-1:0] step_div;
   logic          step_ge;
   logic [CW-1:0] step_diff;

   // Scan datapath.
   logic                          issue;
   logic [CW-1:0]                 limit;
   logic [CW-1:0]                 limit_n;
   logic [bpa_pkg::NBITS_W-1:0]   nvalid;
   logic [bpa_pkg::WORD_BITS-1:0] mask;
   logic [bpa_pkg::WORD_BITS-1:0] cand;
   logic                          zf_found;
   logic [bpa_pkg::BIT_W-1:0]     zf_index;
   logic [bpa_pkg::WORD_BITS-1:0] bit_sel;

   // Growth and free datapath.
   logic [CW-1:0]                 cnt;
   logic [bpa_pkg::RATE_W-1:0]    rate_eff;
   logic [CW-1:0]                 new_total;
   logic                          grp_full;
   logic [CW-1:0]                 grow_wb;
   logic [CW-1:0]                 grow_pos;
   logic [CW-1:0]                 grow_first;
   logic [CW-1:0]                 free_pos;
   logic [CW-1:0]                 free_addr;
   logic [CW-1:0]                 grow_addr;
   logic [CW-1:0]                 found_page;

   bpa_sub_step #(.WIDTH(CW)) u_step (
      .minuend    (rem_ff),
      .subtrahend (step_div),
      .ge         (step_ge),
      .diff       (step_diff)
   );

   bpa_zero_find u_zero_find (
      .cand  (cand),
      .found (zf_found),
      .index (zf_index)
   );

   assign step_div = (state_ff == S_GROW_Q) ? PPG_C : SPAN_C;

   assign limit    = (page_total_ff < MAX_TOTAL_C) ? page_total_ff : MAX_TOTAL_C;
   assign issue    = (scan_w_ff < SCAN_END) && (issue_base_ff < limit);
   assign limit_n  = (limit > chk_base_ff) ? (limit - chk_base_ff) : '0;
   assign nvalid   = (limit_n < CW'(chk_nbits_ff)) ? limit_n[bpa_pkg::NBITS_W-1:0]
                                                   : chk_nbits_ff;
   assign mask     = ~({bpa_pkg::WORD_BITS{1'b1}} << nvalid);
   assign cand     = ~rdata_ff & mask;
   assign found_page = chk_base_ff + CW'(zf_index);

   assign cnt        = (page_total_ff < FIRST_DATA) ? FIRST_DATA : page_total_ff;
   assign rate_eff   = (growth_rate == '0) ? bpa_pkg::RATE_W'(1) : growth_rate;
   assign new_total  = cnt + CW'(rate_eff) + CW'(q_ff);
   assign grp_full   = (diff_ff == PPG_G);
   assign grow_wb    = grp_full ? (wbase_ff + WPG_C) : wbase_ff;
   assign grow_pos   = grp_full ? '0 : CW'(diff_ff);
   assign grow_first = grp_full ? (cnt + CW'(1)) : cnt;
   assign grow_addr  = grow_wb + (grow_pos >> bpa_pkg::BIT_W);
   assign free_pos   = rem_ff - CW'(1);
   assign free_addr  = wbase_ff + (free_pos >> bpa_pkg::BIT_W);

   assign bit_sel = {{(bpa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << upd_bit_ff;
   assign rd_addr = (state_ff == S_SCAN) ? scan_w_ff[AW-1:0] : upd_addr_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pn_in         = pn_ff;
      page_total_in = page_total_ff;
      rem_in        = rem_ff;
      wbase_in      = wbase_ff;
      q_in          = q_ff;
      diff_in       = diff_ff;
      scan_w_in     = scan_w_ff;
      issue_base_in = issue_base_ff;
      grp_left_in   = grp_left_ff;
      chk_v_in      = 1'b0;
      chk_base_in   = chk_base_ff;
      chk_addr_in   = chk_addr_ff;
      chk_nbits_in  = chk_nbits_ff;
      upd_addr_in   = upd_addr_ff;
      upd_bit_in    = upd_bit_ff;
      upd_set_in    = upd_set_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_wa        = upd_addr_ff;
      mem_wd        = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            if (clr_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               pn_in = page_number;
               if (command == bpa_pkg::CMD_FREE) begin
                  res_page_in = page_number;
                  if (page_number == '0 || CW'(page_number) >= page_total_ff) begin
                     res_status_in = bpa_pkg::STATUS_BAD_PAGE;
                     state_in      = S_DONE;
                  end else begin
                     rem_in   = CW'(page_number) - CW'(1);
                     wbase_in = '0;
                     state_in = S_FREE_DIV;
                  end
               end else begin
                  scan_w_in     = '0;
                  issue_base_in = FIRST_DATA;
                  grp_left_in   = PPG_G;
                  state_in      = S_SCAN;
               end
            end
         end
         S_FREE_DIV: begin
            if (step_ge) begin
               rem_in   = step_diff;
               wbase_in = wbase_ff + WPG_C;
            end else if (rem_ff == '0 || wbase_ff >= NWORDS_C) begin
               // Bitmap page, or a group beyond the space.
               res_status_in = bpa_pkg::STATUS_BAD_PAGE;
               state_in      = S_DONE;
            end else begin
               upd_addr_in   = free_addr[AW-1:0];
               upd_bit_in    = free_pos[bpa_pkg::BIT_W-1:0];
               upd_set_in    = 1'b0;
               res_status_in = bpa_pkg::STATUS_OK;
               state_in      = S_RMW_RD;
            end
         end
         S_SCAN: begin
            // Issue one word read per cycle; the word read in the cycle before is checked.
            chk_v_in    = issue;
            chk_base_in = issue_base_ff;
            chk_addr_in = scan_w_ff[AW-1:0];
            if (CW'(grp_left_ff) > WORD_C) begin
               chk_nbits_in = bpa_pkg::NBITS_W'(bpa_pkg::WORD_BITS);
            end else begin
               chk_nbits_in = bpa_pkg::NBITS_W'(grp_left_ff);
            end
            if (issue) begin
               scan_w_in = scan_w_ff + SCW'(1);
               if (CW'(grp_left_ff) > WORD_C) begin
                  grp_left_in   = GLW'(CW'(grp_left_ff) - WORD_C);
                  issue_base_in = issue_base_ff + WORD_C;
               end else begin
                  // Step over the next group's bitmap page.
                  grp_left_in   = PPG_G;
                  issue_base_in = issue_base_ff + CW'(grp_left_ff) + CW'(1);
               end
            end
            if (chk_v_ff && zf_found) begin
               mem_we        = 1'b1;
               mem_wa        = chk_addr_ff;
               mem_wd        = rdata_ff | ({{(bpa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << zf_index);
               res_page_in   = found_page[bpa_pkg::PAGE_W-1:0];
               res_status_in = bpa_pkg::STATUS_OK;
               chk_v_in      = 1'b0;
               state_in      = S_DONE;
            end else if (!chk_v_ff && !issue) begin
               rem_in   = cnt - FIRST_DATA;
               wbase_in = '0;
               state_in = S_GROW_DIV;
            end
         end
         S_GROW_DIV: begin
            if (step_ge) begin
               rem_in   = step_diff;
               wbase_in = wbase_ff + WPG_C;
            end else begin
               diff_in  = rem_ff[GLW-1:0];
               rem_in   = CW'(rate_eff) + rem_ff - CW'(1);
               q_in     = '0;
               state_in = S_GROW_Q;
            end
         end
         S_GROW_Q: begin
            if (step_ge) begin
               rem_in = step_diff;
               q_in   = q_ff + QW'(1);
            end else begin
               state_in = S_GROW_FIN;
            end
         end
         S_GROW_FIN: begin
            if (new_total > MAX_TOTAL_C) begin
               res_page_in   = '0;
               res_status_in = bpa_pkg::STATUS_OUT_OF_SPACE;
               state_in      = S_DONE;
            end else begin
               page_total_in = new_total;
               res_page_in   = grow_first[bpa_pkg::PAGE_W-1:0];
               res_status_in = bpa_pkg::STATUS_OK;
               if (grow_wb < NWORDS_C) begin
                  upd_addr_in = grow_addr[AW-1:0];
                  upd_bit_in  = grow_pos[bpa_pkg::BIT_W-1:0];
                  upd_set_in  = 1'b1;
                  state_in    = S_RMW_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RMW_RD: begin
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            mem_we   = 1'b1;
            mem_wa   = upd_addr_ff;
            mem_wd   = upd_set_ff ? (rdata_ff | bit_sel) : (rdata_ff & ~bit_sel);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         page_total_ff <= INIT_C;
         chk_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         page_total_ff <= page_total_in;
         chk_v_ff      <= chk_v_in;
      end
      pn_ff         <= pn_in;
      rem_ff        <= rem_in;
      wbase_ff      <= wbase_in;
      q_ff          <= q_in;
      diff_ff       <= diff_in;
      scan_w_ff     <= scan_w_in;
      issue_base_ff <= issue_base_in;
      grp_left_ff   <= grp_left_in;
      chk_base_ff   <= chk_base_in;
      chk_addr_ff   <= chk_addr_in;
      chk_nbits_ff  <= chk_nbits_in;
      upd_addr_ff   <= upd_addr_in;
      upd_bit_ff    <= upd_bit_in;
      upd_set_ff    <= upd_set_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign idle          = (state_ff == S_IDLE);
   assign result.valid  = (state_ff == S_DONE);
   assign result.page   = res_page_ff;
   assign result.status = res_status_ff;
   assign result.total  = page_total_ff[bpa_pkg::PAGE_W-1:0];

endmodule

/* src/bitmap_page_allocator.sv */
// Top level of the bitmap page allocator: handshakes, growth rate register, output register.
//
//   channel   direction   handshake       payload
//   req_bus   in          valid / ready   command, page_number
//   rsp_bus   out         valid / ready   result_page, status, total_pages
//   csr_bus   in          valid / ready   growth_rate (always ready)
//
// Allocation scans the usage bitmap one word per cycle until a free page is found or the
// pages in use are searched; failing that it grows the page count, dividing by the group span
// and the growth by PAGES_PER_GROUP. A free divides the page number by the group span.
// After reset a clearing pass zeroes all MAX_GROUPS * words per group words with req ready low.
// A finished result sits in the output register; the next request is taken meanwhile and
// its result waits in the engine until the register is free.
module bitmap_page_allocator #(
   parameter int PAGES_PER_GROUP = bpa_pkg::PAGES_PER_GROUP_DEF,
   parameter int MAX_GROUPS      = bpa_pkg::MAX_GROUPS_DEF,
   parameter int INITIAL_PAGES   = bpa_pkg::INITIAL_PAGES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_bus,
   bpa_rsp_if.source rsp_bus,
   bpa_csr_if.sink   csr_bus
);

   logic [bpa_pkg::RATE_W-1:0]   growth_rate_ff, growth_rate_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::PAGE_W-1:0]   rsp_page_ff;
   logic [bpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [bpa_pkg::PAGE_W-1:0]   rsp_total_ff;
   logic                         eng_idle;
   logic                         start;
   logic                         take;
   bpa_pkg::result_type          eng_result;

   bpa_engine #(
      .PAGES_PER_GROUP (PAGES_PER_GROUP),
      .MAX_GROUPS      (MAX_GROUPS),
      .INITIAL_PAGES   (INITIAL_PAGES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .command     (req_bus.command),
      .page_number (req_bus.page_number),
      .growth_rate (growth_rate_ff),
      .take        (take),
      .idle        (eng_idle),
      .result      (eng_result)
   );

   assign req_bus.ready = eng_idle;
   assign start         = req_bus.valid && eng_idle;
   assign take          = eng_result.valid && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_bus.ready = 1'b1;

   always_comb begin
      growth_rate_in = csr_bus.valid ? csr_bus.growth_rate : growth_rate_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         growth_rate_ff <= bpa_pkg::GROWTH_RATE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         growth_rate_ff <= growth_rate_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (take) begin
         rsp_page_ff   <= eng_result.page;
         rsp_status_ff <= eng_result.status;
         rsp_total_ff  <= eng_result.total;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_page = rsp_page_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.total_pages = rsp_total_ff;

endmodule

/* src/bpa_checker.sv */
// Port-level assertions for the bitmap page allocator and their bind.
module bpa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bpa_pkg::PAGE_W-1:0]   rsp_result_page,
   input logic [bpa_pkg::STATUS_W-1:0] rsp_status,
   input logic [bpa_pkg::PAGE_W-1:0]   rsp_total_pages
);

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_page) &&
                                  $stable(rsp_status) && $stable(rsp_total_pages))
      else $error("response changed while stalled");

   // The block works on one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // Out of space never names a page.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bpa_pkg::STATUS_OUT_OF_SPACE |-> rsp_result_page == '0)
      else $error("out of space with a nonzero page");

   // A successful page lies inside the space and is not the header.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bpa_pkg::STATUS_OK |->
         rsp_result_page != '0 && rsp_result_page < rsp_total_pages)
      else $error("successful page outside the page space");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_result_page (rsp_bus.result_page),
   .rsp_status      (rsp_bus.status),
   .rsp_total_pages (rsp_bus.total_pages)
);
